// ===== sv/vzz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vzz_pkg: shared types and constants of the varint / zigzag codec
// group geometry, result kinds, register indexes and the zigzag helpers
// ----------------------------------------------------------------------------
package vzz_pkg;

  localparam int VALUE_BITS = 32;
  localparam int GROUP_BITS = 7;
  localparam int MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int LEN_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int CONT_POS   = 7;
  localparam int EXT_W      = VALUE_BITS + GROUP_BITS * MAX_GROUPS;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [LEN_W-1:0]      len_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic {
    REG_DIRECTION   = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } reg_idx_t;

  // one pending job: an encode value to split into bytes, or one decode result
  typedef struct packed {
    kind_t  kind;
    value_t value;
    len_t   length;
  } job_t;

  typedef struct packed {
    logic has_job;
    job_t job;
  } front_out_t;

  function automatic value_t zigzag(input value_t v);
    zigzag = {v[VALUE_BITS-2:0], 1'b0} ^ {VALUE_BITS{v[VALUE_BITS-1]}};
  endfunction

  function automatic value_t unzigzag(input value_t z);
    unzigzag = {1'b0, z[VALUE_BITS-1:1]} ^ {VALUE_BITS{z[0]}};
  endfunction

  // 7-bit group number idx of v
  function automatic logic [GROUP_BITS-1:0] group_of(input value_t v, input len_t idx);
    value_t shifted;
    shifted  = v >> (GROUP_BITS * int'(idx));
    group_of = shifted[GROUP_BITS-1:0];
  endfunction

endpackage

// ===== sv/vzz_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vzz_front: per-item front logic
// encode: zigzag and length of the value; decode: group accumulator and end test
// ----------------------------------------------------------------------------
module vzz_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  direction,
  input  logic                  signed_mode,
  input  vzz_pkg::value_t       value_in,
  input  logic [7:0]            code_byte,
  input  logic                  buffer_end,
  output vzz_pkg::front_out_t   fo
);
  import vzz_pkg::*;

  value_t acc_r, acc_nxt;
  len_t   gidx_r, gidx_nxt;

  value_t               enc_v;
  len_t                 enc_n;
  len_t                 gi;
  len_t                 count;
  logic [EXT_W-1:0]     placed;
  value_t               acc_new;
  logic                 cont;

  // encode side
  always_comb begin
    enc_v = signed_mode ? zigzag(value_in) : value_in;
    enc_n = len_t'(1);
    for (int k = 1; k < MAX_GROUPS; k++) begin
      if ((enc_v >> (GROUP_BITS * k)) != '0) begin
        enc_n = len_t'(k + 1);
      end
    end
  end

  // decode side
  always_comb begin
    gi      = (gidx_r >= len_t'(MAX_GROUPS)) ? '0 : gidx_r;
    placed  = EXT_W'(code_byte[GROUP_BITS-1:0]) << (GROUP_BITS * int'(gi));
    acc_new = acc_r | placed[VALUE_BITS-1:0];
    count   = gi + len_t'(1);
    cont    = code_byte[CONT_POS];
  end

  always_comb begin
    fo       = '0;
    acc_nxt  = acc_r;
    gidx_nxt = gidx_r;
    if (!direction) begin
      fo.has_job    = 1'b1;
      fo.job.kind   = KIND_BYTE;
      fo.job.value  = enc_v;
      fo.job.length = enc_n;
    end else begin
      fo.job.length = count;
      if (!cont) begin
        fo.has_job    = 1'b1;
        fo.job.kind   = KIND_VALUE;
        fo.job.value  = signed_mode ? unzigzag(acc_new) : acc_new;
        acc_nxt       = '0;
        gidx_nxt      = '0;
      end else if (count >= len_t'(MAX_GROUPS) || buffer_end) begin
        fo.has_job    = 1'b1;
        fo.job.kind   = KIND_ERROR;
        acc_nxt       = '0;
        gidx_nxt      = '0;
      end else begin
        acc_nxt       = acc_new;
        gidx_nxt      = count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      gidx_r <= '0;
    end else if (accept && direction) begin
      acc_r  <= acc_nxt;
      gidx_r <= gidx_nxt;
    end
  end

endmodule

// ===== sv/vzz_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vzz_serializer: job register and result register
// splits an encode job into its bytes, one per cycle unless out_stall holds, into the output register
// ----------------------------------------------------------------------------
module vzz_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_push,
  input  vzz_pkg::job_t     job_in,
  output logic              job_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte,
  output vzz_pkg::value_t   out_value,
  output vzz_pkg::len_t     out_length,
  output logic              out_last
);
  import vzz_pkg::*;

  job_t   job_r;
  logic   job_valid_r, job_valid_nxt;
  len_t   idx_r, idx_nxt;

  logic               vld_r, vld_nxt;
  kind_t              kind_r;
  logic [BYTE_W-1:0]  byte_r;
  value_t             value_r;
  len_t               len_r;
  logic               last_r;

  logic               take;
  logic               move;
  logic               res_last;
  logic [BYTE_W-1:0]  res_byte;
  value_t             res_value;

  assign take      = !vld_r || !out_stall;
  assign move      = take && job_valid_r;
  assign job_ready = !job_valid_r || (move && res_last);

  always_comb begin
    res_byte  = '0;
    res_value = '0;
    res_last  = 1'b1;
    case (job_r.kind)
      KIND_BYTE: begin
        res_last  = (idx_r == job_r.length - len_t'(1));
        res_byte  = {!res_last, group_of(job_r.value, idx_r)};
      end
      KIND_VALUE: begin
        res_value = job_r.value;
      end
      default: begin
        res_value = '0;
      end
    endcase
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    idx_nxt       = idx_r;
    if (job_push) begin
      job_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (move && res_last) begin
      job_valid_nxt = 1'b0;
    end else if (move) begin
      idx_nxt       = idx_r + len_t'(1);
    end
    vld_nxt = take ? job_valid_r : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      vld_r       <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
      vld_r       <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) begin
      job_r <= job_in;
    end
    if (move) begin
      kind_r  <= job_r.kind;
      byte_r  <= res_byte;
      value_r <= res_value;
      len_r   <= job_r.length;
      last_r  <= res_last;
    end
  end

  assign out_valid  = vld_r;
  assign out_kind   = kind_r;
  assign out_byte   = byte_r;
  assign out_value  = value_r;
  assign out_length = len_r;
  assign out_last   = last_r;

endmodule

// ===== sv/varint_zigzag_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_zigzag_codec: base-128 varint codec for 32-bit values with zigzag
// encode splits a value into 1 to 5 bytes; decode assembles bytes into values
// ----------------------------------------------------------------------------
// usage
//   cfg port: cfg_we writes cfg_wdata to register cfg_index (0 direction,
//   1 signed_mode); write only while no item is in flight
//   input channel: in_valid / in_stall, fields value_in, code_byte, buffer_end
//   result channel: out_valid / out_stall, fields kind, byte, value, length, last
//   encode: each item yields 1 to 5 byte results, out_last on the final one
//   decode: each byte updates the group accumulator; a terminating byte gives
//   one value result, an unterminated fifth or buffer-end byte one error
//   path: the first result of an item goes from the job register into the
//   result register, which drives out_valid
//   throughput: one item per cycle in decode and one result per cycle in encode,
//   while out_stall is low; the job register drains an encode item byte by byte
//   stall: out_stall holds the result register; the job register then stays
//   full and in_stall rises until the job can move on
//   reset: rst_n low clears config, decode state and all valid flags
// ----------------------------------------------------------------------------
module varint_zigzag_codec (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  vzz_pkg::value_t       in_value_in,
  input  logic [7:0]            in_code_byte,
  input  logic                  in_buffer_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_byte,
  output vzz_pkg::value_t       out_value,
  output vzz_pkg::len_t         out_length,
  output logic                  out_last
);
  import vzz_pkg::*;

  // configuration registers
  logic direction_r, direction_nxt;
  logic signed_r, signed_nxt;

  always_comb begin
    direction_nxt = direction_r;
    signed_nxt    = signed_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DIRECTION:   direction_nxt = cfg_wdata;
        REG_SIGNED_MODE: signed_nxt    = cfg_wdata;
        default:         direction_nxt = direction_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      signed_r    <= 1'b0;
    end else begin
      direction_r <= direction_nxt;
      signed_r    <= signed_nxt;
    end
  end

  // an item is taken whenever the job register is free or empties this cycle
  logic        accept;
  logic        job_ready;
  front_out_t  fo;

  assign in_stall = !job_ready;
  assign accept   = in_valid && !in_stall;

  // encode prep and decode accumulator
  vzz_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .direction   (direction_r),
    .signed_mode (signed_r),
    .value_in    (in_value_in),
    .code_byte   (in_code_byte),
    .buffer_end  (in_buffer_end),
    .fo          (fo)
  );

  // job register plus output register, bytes leave one per cycle unless out_stall holds
  vzz_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_push   (accept && fo.has_job),
    .job_in     (fo.job),
    .job_ready  (job_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_value  (out_value),
    .out_length (out_length),
    .out_last   (out_last)
  );

`ifndef SYNTHESIS
  // value and error results are always the single result of their item
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_BYTE) |-> out_last)
    else $error("decode result without last flag");

  // continuation bit set exactly on non-final encoded bytes
  a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BYTE) |-> (out_byte[7] == !out_last))
    else $error("continuation bit does not match last flag");

  // encode length covers at least one byte and at most five
  a_enc_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BYTE) |->
      (out_length != '0) && (out_length <= len_t'(MAX_GROUPS)))
    else $error("encoded length out of range");
`endif

endmodule
